// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the multilane byte hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define MH_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/mhash_pkg.sv -----
// Package with the types, constants and helper functions of the multilane byte hash.
package mhash_pkg;

  localparam int LANE_COUNT_DEF = 32;
  localparam int LANE_W         = 32;
  localparam int CNT_MAX_W      = 7;   // holds lane counts up to 64 plus two ring stages
  localparam int POS_W          = 5;
  localparam int IDX_W          = 6;
  localparam int FIN_ROUNDS     = 4;

  localparam logic [31:0] K_BYTE   = 32'h9e3779b1;
  localparam logic [31:0] K_LANE   = 32'h85ebca6b;
  localparam logic [31:0] K_MIX    = 32'h27d4eb2d;
  localparam logic [31:0] K_FIN1   = 32'h85ebca6b;
  localparam logic [31:0] K_FIN2   = 32'hc2b2ae35;
  localparam logic [31:0] XS_SEED  = 32'h9e3779b1;
  localparam logic [4:0]  ROT_STEP = 5'd7;

  localparam logic [31:0] LANE_INIT [32] = '{
    32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
    32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
    32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
    32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917,
    32'h9216d5d9, 32'h8979fb1b, 32'hd1310ba6, 32'h98dfb5ac,
    32'h2ffd72db, 32'hd01adfb7, 32'hb8e1afed, 32'h6a267e96,
    32'hba7c9045, 32'hf12c7f99, 32'h24a19947, 32'hb3916cf7,
    32'h0801f2e2, 32'h858efc16, 32'h636920d8, 32'h71574e69
  };

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ABSORB,
    OP_FINAL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // Control bundle from the sequencer to the lane ring and the mix stages.
  typedef struct packed {
    op_t                   op;
    logic                  shift;
    logic [CNT_MAX_W-1:0]  lane;
    logic [POS_W-1:0]      pos;
    logic [LANE_W-1:0]     acc;
    logic                  emit_take;
    logic                  reload;
  } ctl_t;

  // Reset value of lane k: the fixed table, then an xorshift32 sequence.
  function automatic logic [31:0] lane_init(input int k);
    logic [31:0] s;
    s = XS_SEED;
    if (k < 32) begin
      return LANE_INIT[k];
    end
    for (int j = 32; j <= k; j++) begin
      s = s ^ (s << 13);
      s = s ^ (s >> 17);
      s = s ^ (s << 5);
    end
    return s;
  endfunction

  // Rotate left; a zero amount leaves the word unchanged.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] a);
    logic [63:0] w;
    w = {v, v} << a;
    return w[63:32];
  endfunction

endpackage

// ----- hw/rtl/mhash_channels.sv -----
// Handshake interfaces for the input byte channel and the digest word channel.
interface mhash_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source(output valid, output data_byte, output has_byte, output end_of_message,
                 input ready);
  modport sink(input valid, input data_byte, input has_byte, input end_of_message,
               output ready);
endinterface

interface mhash_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [5:0]  word_index;
  logic        last_word;

  modport source(output valid, output digest_word, output word_index, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input word_index, input last_word,
               output ready);
endinterface

// ----- hw/rtl/mhash_cell.sv -----
// One lane cell of the ring: holds a lane word and passes it to its neighbor.
module mhash_cell #(
  parameter logic [31:0] INIT = 32'h0
) (
  input  logic        clk,
  input  logic        load,
  input  logic        shift,
  input  logic [31:0] d_in,
  output logic [31:0] q
);
  logic [31:0] word_r;

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= INIT;
    end else if (shift) begin
      word_r <= d_in;
    end
  end

  assign q = word_r;
endmodule

// ----- hw/rtl/mhash_mix.sv -----
// Three-stage lane mixer that closes the ring: absorb, finalize or pass a lane word.
module mhash_mix (
  input  logic              clk,
  input  mhash_pkg::ctl_t   ctl,
  input  logic [31:0]       v_in,
  output logic [31:0]       v_out
);
  import mhash_pkg::*;

  logic [31:0] p1_v_r, p1_v_nxt;
  logic [31:0] p1_p_r, p1_p_nxt;
  logic [31:0] p2_v_r, p2_v_nxt;
  logic [4:0]  rot_amt;
  logic [31:0] rot_v;
  logic [31:0] mul_a;
  logic [31:0] mul_k;
  logic [31:0] mul_a_p;
  logic [31:0] fin_b;

  // Stage A: xor with the byte/lane term and rotate, then one shared multiplier.
  always_comb begin
    rot_amt = ctl.lane[4:0] * ROT_STEP + ctl.pos;
    rot_v   = rotl32(v_in ^ ctl.acc, rot_amt);
    if (ctl.op == OP_FINAL) begin
      mul_a = v_in ^ (v_in >> 15);
      mul_k = K_FIN1;
    end else begin
      mul_a = rot_v ^ (rot_v >> 16);
      mul_k = K_MIX;
    end
    mul_a_p = mul_a * mul_k;
    case (ctl.op)
      OP_ABSORB: begin
        p1_v_nxt = rot_v;
        p1_p_nxt = mul_a_p;
      end
      OP_FINAL: begin
        p1_v_nxt = mul_a_p;
        p1_p_nxt = mul_a_p;
      end
      default: begin
        p1_v_nxt = v_in;
        p1_p_nxt = v_in;
      end
    endcase
  end

  // Stage B: the add of the absorb mix, or the second finalization multiply.
  always_comb begin
    fin_b = p1_v_r ^ (p1_v_r >> 13);
    case (ctl.op)
      OP_ABSORB: p2_v_nxt = p1_v_r + p1_p_r;
      OP_FINAL:  p2_v_nxt = fin_b * K_FIN2;
      default:   p2_v_nxt = p1_v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      p1_v_r <= p1_v_nxt;
      p1_p_r <= p1_p_nxt;
      p2_v_r <= p2_v_nxt;
    end
  end

  // Stage C: last xor-shift of a finalization round.
  assign v_out = (ctl.op == OP_FINAL) ? (p2_v_r ^ (p2_v_r >> 16)) : p2_v_r;
endmodule

// ----- hw/rtl/mhash_ctrl.sv -----
// Sequencer: steps the lane ring through absorb, finalize and emit passes.
`include "assert_macros.svh"

module mhash_ctrl #(
  parameter int LANE_COUNT = mhash_pkg::LANE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            has_byte,
  input  logic            end_of_message,
  input  logic            out_free,
  output mhash_pkg::ctl_t ctl
);
  import mhash_pkg::*;

  localparam int CNT_W = $clog2(LANE_COUNT + 2);
  localparam logic [CNT_W-1:0] N_C      = CNT_W'(LANE_COUNT);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LANE_COUNT + 1);
  localparam logic [1:0]       LAST_RND = 2'(FIN_ROUNDS - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        round_r, round_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              eom_r, eom_nxt;
  logic              in_fire;
  logic              shift;
  logic              pass_end;
  logic              lane_slot;

  assign in_fire   = in_valid && in_ready;
  assign lane_slot = cnt_r < N_C;

  // Outputs of the sequencer.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_ABSORB: shift = 1'b1;
      ST_FINAL:  shift = 1'b1;
      ST_EMIT:   shift = !lane_slot || out_free;
      default:   shift = 1'b0;
    endcase
    pass_end = shift && (cnt_r == LAST_CNT);

    case (state_r)
      ST_ABSORB: ctl.op = OP_ABSORB;
      ST_FINAL:  ctl.op = OP_FINAL;
      default:   ctl.op = OP_PASS;
    endcase
    ctl.shift     = shift;
    ctl.lane      = CNT_MAX_W'(cnt_r);
    ctl.pos       = pos_r;
    ctl.acc       = acc_r;
    ctl.emit_take = (state_r == ST_EMIT) && shift && lane_slot;
    ctl.reload    = (state_r == ST_EMIT) && pass_end;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_byte) begin
            state_nxt = ST_ABSORB;
          end else if (end_of_message) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_ABSORB: begin
        if (pass_end) begin
          state_nxt = eom_r ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (pass_end && (round_r == LAST_RND)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pass_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Counters and datapath registers.
  always_comb begin
    cnt_nxt   = cnt_r;
    round_nxt = round_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    eom_nxt   = eom_r;
    if (shift) begin
      cnt_nxt = pass_end ? '0 : cnt_r + 1'b1;
    end
    if (in_fire) begin
      acc_nxt = {24'd0, data_byte} * K_BYTE;
      eom_nxt = end_of_message;
    end else if ((state_r == ST_ABSORB) && shift) begin
      acc_nxt = acc_r + K_LANE;
    end
    if ((state_r == ST_ABSORB) && pass_end) begin
      pos_nxt = pos_r + 1'b1;
    end
    if ((state_r == ST_FINAL) && pass_end) begin
      round_nxt = round_r + 1'b1;
    end
    if ((state_r == ST_EMIT) && pass_end) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      round_r <= '0;
      pos_r   <= '0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      round_r <= round_nxt;
      pos_r   <= pos_nxt;
      eom_r   <= eom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  `MH_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > LAST_CNT, "ring step count out of range")
  `MH_ASSERT(a_reload_idle, clk, rst_n, ctl.reload |=> (state_r == ST_IDLE) && (pos_r == '0), "reload must end in idle with position cleared")
  `MH_ASSERT_NEVER(a_round_final, clk, rst_n, (state_r != ST_FINAL) && (round_r != 2'd0), "round count left nonzero outside finalization")
endmodule

// ----- hw/rtl/multilane_byte_hash_top.sv -----
// Top level of the multilane byte hash: lane ring, mixer, sequencer, output register.
//
// in_ch takes one word per message byte: data_byte with has_byte set, or an
// end-only word with has_byte clear. end_of_message on a word finalizes after it.
// out_ch returns LANE_COUNT digest words per message, lane 0 first, with
// word_index giving the lane and last_word marking lane LANE_COUNT-1.
// The lane words circulate in a ring of LANE_COUNT cells closed by a
// three-stage mixer (two pipeline registers); each pass brings every lane once
// through the mixer. A byte word takes one absorb pass, and an end-of-message
// word adds four finalization passes and one emit pass; the digest words are
// captured during the emit pass. in_ready is high only between items, so the
// block takes no new word until the last one is through.
// A stalled out_ch holds the ring during the emit pass; the words are never
// dropped. After the last digest word leaves the ring, the lanes reload their
// initial values and the byte position returns to zero.
// Reset (rst_n low, synchronous) loads the initial lane values.
`include "assert_macros.svh"

module multilane_byte_hash_top #(
  parameter int LANE_COUNT = mhash_pkg::LANE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mhash_in_if.sink   in_ch,
  mhash_out_if.source out_ch
);
  import mhash_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LANE_COUNT - 1);

  ctl_t        ctl;
  logic [31:0] lane_q [LANE_COUNT];
  logic [31:0] mix_out;
  logic        ring_load;
  logic        out_free;

  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_word_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  assign ring_load = !rst_n || ctl.reload;
  assign out_free  = !out_valid_r || out_ch.ready;

  mhash_ctrl #(
    .LANE_COUNT(LANE_COUNT)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .data_byte     (in_ch.data_byte),
    .has_byte      (in_ch.has_byte),
    .end_of_message(in_ch.end_of_message),
    .out_free      (out_free),
    .ctl           (ctl)
  );

  mhash_mix u_mix (
    .clk  (clk),
    .ctl  (ctl),
    .v_in (lane_q[0]),
    .v_out(mix_out)
  );

  for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
    if (i == LANE_COUNT - 1) begin : g_tail
      mhash_cell #(
        .INIT(lane_init(i))
      ) u_cell (
        .clk  (clk),
        .load (ring_load),
        .shift(ctl.shift),
        .d_in (mix_out),
        .q    (lane_q[i])
      );
    end else begin : g_body
      mhash_cell #(
        .INIT(lane_init(i))
      ) u_cell (
        .clk  (clk),
        .load (ring_load),
        .shift(ctl.shift),
        .d_in (lane_q[i+1]),
        .q    (lane_q[i])
      );
    end
  end

  // The digest word is captured as its lane leaves the head cell.
  always_comb begin
    if (ctl.emit_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_take) begin
      out_word_r <= lane_q[0];
      out_idx_r  <= ctl.lane[IDX_W-1:0];
      out_last_r <= (ctl.lane[IDX_W-1:0] == IDX_LAST);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = out_last_r;

  `MH_ASSERT(a_last_index, clk, rst_n, out_valid_r |-> (out_last_r == (out_idx_r == IDX_LAST)), "last_word disagrees with word_index")
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the multilane byte hash: directed and random messages.
module testbench;

  localparam int LANES = 32;

  localparam logic [31:0] HK_BYTE = 32'h9e3779b1;
  localparam logic [31:0] HK_LANE = 32'h85ebca6b;
  localparam logic [31:0] HK_MIX  = 32'h27d4eb2d;
  localparam logic [31:0] HK_FIN1 = 32'h85ebca6b;
  localparam logic [31:0] HK_FIN2 = 32'hc2b2ae35;
  localparam int          FIN_PASSES = 4;

  localparam logic [31:0] LANE_SEED [32] = '{
    32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
    32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
    32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
    32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917,
    32'h9216d5d9, 32'h8979fb1b, 32'hd1310ba6, 32'h98dfb5ac,
    32'h2ffd72db, 32'hd01adfb7, 32'hb8e1afed, 32'h6a267e96,
    32'hba7c9045, 32'hf12c7f99, 32'h24a19947, 32'hb3916cf7,
    32'h0801f2e2, 32'h858efc16, 32'h636920d8, 32'h71574e69
  };

  typedef struct {
    logic [31:0] word;
    logic [5:0]  index;
    logic        last;
  } digest_entry_t;

  logic clk = 1'b0;
  logic rst_n;

  mhash_in_if  in_ch();
  mhash_out_if out_ch();

  multilane_byte_hash_top #(.LANE_COUNT(LANES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  logic [31:0]   lane_state [LANES];
  logic [4:0]    byte_pos;
  digest_entry_t digest_q [$];
  int            errors = 0;
  int            in_idle_pct = 0;
  int            out_idle_pct = 0;

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input logic [4:0] amt);
    if (amt == 5'd0) begin
      return v;
    end
    return (v << amt) | (v >> (32 - amt));
  endfunction

  function void reload_lanes();
    for (int k = 0; k < LANES; k++) begin
      lane_state[k] = LANE_SEED[k];
    end
    byte_pos = 5'd0;
  endfunction

  function void absorb_byte(input logic [7:0] b);
    logic [31:0] t;
    logic [31:0] v;
    t = {24'd0, b} * HK_BYTE;
    for (int k = 0; k < LANES; k++) begin
      v = lane_state[k] ^ (t + 32'(k) * HK_LANE);
      v = rotate_left(v, 5'(k * 7) + byte_pos);
      v = v + ((v ^ (v >> 16)) * HK_MIX);
      lane_state[k] = v;
    end
    byte_pos = byte_pos + 5'd1;
  endfunction

  // Finalizes every lane, queues the digest words in lane order and restarts.
  function void finish_message();
    logic [31:0]   v;
    digest_entry_t e;
    for (int r = 0; r < FIN_PASSES; r++) begin
      for (int k = 0; k < LANES; k++) begin
        v = lane_state[k];
        v = v ^ (v >> 15);
        v = v * HK_FIN1;
        v = v ^ (v >> 13);
        v = v * HK_FIN2;
        v = v ^ (v >> 16);
        lane_state[k] = v;
      end
    end
    for (int k = 0; k < LANES; k++) begin
      e.word  = lane_state[k];
      e.index = 6'(k);
      e.last  = (k == LANES - 1);
      digest_q.push_back(e);
    end
    reload_lanes();
  endfunction

  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data;
    in_ch.has_byte       <= has;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    if (has) begin
      absorb_byte(data);
    end
    if (eom) begin
      finish_message();
    end
  endtask

  // Drops valid and holds off until every queued digest word has come back.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    digest_entry_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h at index %0d", out_ch.digest_word,
               out_ch.word_index);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (out_ch.digest_word !== e.word) begin
          $error("digest_word: expected %h, got %h", e.word, out_ch.digest_word);
          errors++;
        end
        if (out_ch.word_index !== e.index) begin
          $error("word_index: expected %0d, got %0d", e.index, out_ch.word_index);
          errors++;
        end
        if (out_ch.last_word !== e.last) begin
          $error("last_word: expected %0b, got %0b", e.last, out_ch.last_word);
          errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
  endtask

  // Words with neither a byte nor an end must leave the lanes untouched,
  // whatever their data byte holds.
  task automatic test_ignored_items();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hfe, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hc3, 1'b0, 1'b1);
  endtask

  // A second empty message right after a digest checks that the lanes reload.
  task automatic test_pause_after_digest();
    send_item(8'h7f, 1'b1, 1'b1);
    wait_drain();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages(input int in_pct, input int out_pct, input int goal,
                                      input bit with_long);
    int counted;
    int len;
    bit long_done;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    counted      = 0;
    long_done    = !with_long;
    while (counted < goal) begin
      // One message runs past 32 bytes so that the byte position wraps.
      if (!long_done) begin
        len       = $urandom_range(40, 33);
        long_done = 1'b1;
      end else begin
        len = $urandom_range(6, 0);
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          send_item(8'($urandom), 1'b0, 1'b0);
        end
        send_item(8'($urandom), 1'b1, 1'b0);
        counted++;
      end
      if (len > 0 && $urandom_range(1) == 1) begin
        send_item(8'($urandom), 1'b1, 1'b1);
      end else begin
        send_item(8'($urandom), 1'b0, 1'b1);
      end
      counted++;
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = 8'h00;
    in_ch.has_byte       = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    reload_lanes();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 35;
    out_idle_pct = 82;
    test_empty_message();
    test_field_extremes();
    test_ignored_items();
    test_pause_after_digest();

    test_random_messages(35, 82, 20, 1'b0);
    test_random_messages(82, 35, 20, 1'b0);
    test_random_messages(0, 0, 36, 1'b1);

    wait_drain();
    // A trailing byte word may still be in the ring; give it a full byte time and more.
    repeat (4 * (LANES + 3)) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- multilane_byte_hash_top.f -----
+incdir+hw/rtl
hw/rtl/mhash_pkg.sv
hw/rtl/mhash_channels.sv
hw/rtl/mhash_cell.sv
hw/rtl/mhash_mix.sv
hw/rtl/mhash_ctrl.sv
hw/rtl/multilane_byte_hash_top.sv
verif/testbench.sv
